>>> sv/m2tsphi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// M2TS PCR header interpolator package
// Shared widths, codes and the command record passed from front to back end.
// ----------------------------------------------------------------------------
package m2tsphi_pkg;

   localparam int unsigned PCR_W      = 42;
   localparam int unsigned STAMP_W    = 30;
   localparam int unsigned HELD_W     = 6;
   localparam int unsigned OFF_W      = 7;
   localparam int unsigned DEN_W      = 7;
   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 32;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [PCR_W-1:0] PCR_RANGE = 42'd2576980377600;

   localparam logic [KIND_W-1:0] REQ_PLAIN = 2'd0;
   localparam logic [KIND_W-1:0] REQ_PCR   = 2'd1;
   localparam logic [KIND_W-1:0] REQ_DRAIN = 2'd2;

   localparam logic [KIND_W-1:0] KIND_HELD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CURRENT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd2;

   localparam logic [OFF_W-1:0] OFF_FLOOR = 7'b1000000;
   localparam logic [OFF_W-1:0] OFF_AFTER = 7'b1111111;

   typedef struct packed {
      logic                 release_run;
      logic                 has_tail;
      logic [KIND_W-1:0]    kind;
      logic [STAMP_W-1:0]   stamp;
      logic [HELD_W-1:0]    count;
      logic [STAMP_W-1:0]   anchor;
      logic [OFF_W-1:0]     offset;
      logic [PCR_W-1:0]     rate_num;
      logic [DEN_W-1:0]     rate_den;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

>>> sv/m2tsphi_cmd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// M2TS PCR header interpolator command queue
// Short register queue that decouples the classifier from the release engine.
// ----------------------------------------------------------------------------
module m2tsphi_cmd_queue (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              push,
   input  m2tsphi_pkg::cmd_type             push_cmd,
   input  wire                              pop,
   output m2tsphi_pkg::cmd_type             head_cmd,
   output m2tsphi_pkg::queue_status_type    status
);

   localparam int unsigned DEPTH = m2tsphi_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   m2tsphi_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_cmd     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) push |-> !status.full)
      else $error("Command pushed into a full queue.");
   assert property (@(posedge clock) disable iff (reset) pop |-> !status.empty)
      else $error("Command popped from an empty queue.");
`endif

endmodule
`default_nettype wire

>>> sv/m2tsphi_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// M2TS PCR header interpolator front end
// Accepts packet items, keeps the hold count, anchor and rate, and issues
// release commands to the back end.
// ----------------------------------------------------------------------------
module m2tsphi_front #(
   parameter int unsigned HOLD_DEPTH = 32
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_tvalid,
   output logic                                    req_tready,
   input  wire [m2tsphi_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  wire [m2tsphi_pkg::KIND_W-1:0]           req_tuser,
   input  wire                                     csr_wr_en,
   input  wire                                     csr_wr_data,
   input  m2tsphi_pkg::queue_status_type           queue_status,
   output logic                                    push,
   output m2tsphi_pkg::cmd_type                    push_cmd
);

   localparam logic [m2tsphi_pkg::HELD_W-1:0] HOLD_LIMIT =
      HOLD_DEPTH[m2tsphi_pkg::HELD_W-1:0];
   localparam logic signed [m2tsphi_pkg::OFF_W:0] OFF_MIN8 = -8'sd64;

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_EVAL = 2'b10
   } front_state_type;

   front_state_type state_ff, state_in;

   logic [m2tsphi_pkg::KIND_W-1:0]  req_ff;
   logic [m2tsphi_pkg::PCR_W-1:0]   pcr_ff;
   logic                            enable_ff;
   logic [m2tsphi_pkg::HELD_W-1:0]  held_ff, held_in;
   logic [m2tsphi_pkg::PCR_W-1:0]   anchor_ff, anchor_in;
   logic [m2tsphi_pkg::PCR_W-1:0]   gap_ff, gap_in;
   logic                            anchor_valid_ff, anchor_valid_in;
   logic [m2tsphi_pkg::OFF_W-1:0]   offset_ff, offset_in;
   logic [m2tsphi_pkg::PCR_W-1:0]   num_ff, num_in;
   logic [m2tsphi_pkg::DEN_W-1:0]   den_ff, den_in;

   logic [m2tsphi_pkg::PCR_W-1:0]   pcr_raw;
   logic [m2tsphi_pkg::PCR_W-1:0]   pcr_red;
   logic [m2tsphi_pkg::PCR_W:0]     diff;
   logic [m2tsphi_pkg::PCR_W:0]     wrap_sum;
   logic [m2tsphi_pkg::PCR_W-1:0]   num_new;
   logic [m2tsphi_pkg::OFF_W:0]     den_calc;
   logic [m2tsphi_pkg::OFF_W:0]     drain_off;
   logic                            hold_full;
   logic                            fresh;
   logic                            need;
   logic                            go;
   m2tsphi_pkg::cmd_type            cmd;

   assign req_tready = (state_ff == F_IDLE);
   assign pcr_raw    = req_tdata[m2tsphi_pkg::PCR_W-1:0];
   assign pcr_red    = (pcr_raw >= m2tsphi_pkg::PCR_RANGE) ?
                       pcr_raw - m2tsphi_pkg::PCR_RANGE : pcr_raw;

   assign diff      = {1'b0, pcr_ff} - {1'b0, anchor_ff};
   assign wrap_sum  = {1'b0, pcr_ff} + {1'b0, gap_ff};
   assign num_new   = diff[m2tsphi_pkg::PCR_W] ? wrap_sum[m2tsphi_pkg::PCR_W-1:0] :
                      diff[m2tsphi_pkg::PCR_W-1:0];
   assign den_calc  = {2'b00, held_ff} - {offset_ff[m2tsphi_pkg::OFF_W-1], offset_ff};
   assign drain_off = {offset_ff[m2tsphi_pkg::OFF_W-1], offset_ff} - {2'b00, held_ff};
   assign hold_full = (held_ff >= HOLD_LIMIT);
   assign fresh     = !anchor_valid_ff || (pcr_ff != anchor_ff);

   always_comb begin
      need            = 1'b0;
      cmd             = '0;
      held_in         = held_ff;
      anchor_in       = anchor_ff;
      gap_in          = gap_ff;
      anchor_valid_in = anchor_valid_ff;
      offset_in       = offset_ff;
      num_in          = num_ff;
      den_in          = den_ff;
      case (req_ff)
         m2tsphi_pkg::REQ_DRAIN: begin
            if (anchor_valid_ff && (held_ff != '0)) begin
               need             = 1'b1;
               cmd.release_run  = 1'b1;
               cmd.count        = held_ff;
               cmd.anchor       = anchor_ff[m2tsphi_pkg::STAMP_W-1:0];
               cmd.offset       = offset_ff;
               cmd.rate_num     = num_ff;
               cmd.rate_den     = den_ff;
               held_in          = '0;
               offset_in        = ($signed(drain_off) < OFF_MIN8) ?
                                  m2tsphi_pkg::OFF_FLOOR : drain_off[m2tsphi_pkg::OFF_W-1:0];
            end
         end
         m2tsphi_pkg::REQ_PLAIN, m2tsphi_pkg::REQ_PCR: begin
            if (!enable_ff) begin
               need     = 1'b1;
               cmd.kind = m2tsphi_pkg::KIND_CURRENT;
            end else if ((req_ff == m2tsphi_pkg::REQ_PLAIN) ||
                         (!anchor_valid_ff && (held_ff != '0))) begin
               if (hold_full) begin
                  need     = 1'b1;
                  cmd.kind = m2tsphi_pkg::KIND_DROPPED;
               end else begin
                  if (req_ff == m2tsphi_pkg::REQ_PCR) begin
                     anchor_in       = pcr_ff;
                     gap_in          = m2tsphi_pkg::PCR_RANGE - pcr_ff;
                     anchor_valid_in = 1'b1;
                     offset_in       = {1'b0, held_ff};
                  end
                  held_in = held_ff + 1'b1;
               end
            end else begin
               need      = 1'b1;
               cmd.kind  = m2tsphi_pkg::KIND_CURRENT;
               cmd.stamp = pcr_ff[m2tsphi_pkg::STAMP_W-1:0];
               if (fresh && (held_ff != '0)) begin
                  cmd.release_run = 1'b1;
                  cmd.has_tail    = 1'b1;
                  cmd.count       = held_ff;
                  cmd.anchor      = anchor_ff[m2tsphi_pkg::STAMP_W-1:0];
                  cmd.offset      = offset_ff;
                  cmd.rate_num    = num_new;
                  cmd.rate_den    = den_calc[m2tsphi_pkg::DEN_W-1:0];
                  num_in          = num_new;
                  den_in          = den_calc[m2tsphi_pkg::DEN_W-1:0];
                  held_in         = '0;
               end
               if (fresh) begin
                  anchor_in       = pcr_ff;
                  gap_in          = m2tsphi_pkg::PCR_RANGE - pcr_ff;
                  anchor_valid_in = 1'b1;
                  offset_in       = m2tsphi_pkg::OFF_AFTER;
               end
            end
         end
         default: begin
         end
      endcase
      go       = (state_ff == F_EVAL) && (!need || !queue_status.full);
      push     = go && need;
      push_cmd = cmd;
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               state_in = F_EVAL;
            end
         end
         F_EVAL: begin
            if (go) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= F_IDLE;
         enable_ff       <= 1'b0;
         held_ff         <= '0;
         anchor_ff       <= '0;
         gap_ff          <= m2tsphi_pkg::PCR_RANGE;
         anchor_valid_ff <= 1'b0;
         offset_ff       <= '0;
         num_ff          <= m2tsphi_pkg::PCR_W'(1);
         den_ff          <= m2tsphi_pkg::DEN_W'(1);
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
         if (go) begin
            held_ff         <= held_in;
            anchor_ff       <= anchor_in;
            gap_ff          <= gap_in;
            anchor_valid_ff <= anchor_valid_in;
            offset_ff       <= offset_in;
            num_ff          <= num_in;
            den_ff          <= den_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff <= req_tuser;
         pcr_ff <= pcr_red;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) held_ff <= HOLD_LIMIT)
      else $error("Hold count exceeds the hold depth.");
`endif

endmodule
`default_nettype wire

>>> sv/m2tsphi_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// M2TS PCR header interpolator back end
// Divides the rate once per release, then steps an interpolation accumulator
// across the held packets and drives the result register.
// ----------------------------------------------------------------------------
module m2tsphi_back (
   input  wire                                     clock,
   input  wire                                     reset,
   input  m2tsphi_pkg::cmd_type                    head_cmd,
   input  m2tsphi_pkg::queue_status_type           queue_status,
   output logic                                    pop,
   output logic                                    rsp_tvalid,
   input  wire                                     rsp_tready,
   output logic [m2tsphi_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [m2tsphi_pkg::KIND_W-1:0]          rsp_tuser,
   output logic                                    rsp_tlast
);

   localparam int unsigned SW  = m2tsphi_pkg::STAMP_W;
   localparam int unsigned DW  = m2tsphi_pkg::DEN_W;
   localparam int unsigned PW  = m2tsphi_pkg::PCR_W;
   localparam int unsigned BCW = $clog2(PW + 1);

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_DIV  = 5'b00010,
      B_WALK = 5'b00100,
      B_EMIT = 5'b01000,
      B_TAIL = 5'b10000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic                            has_tail_ff;
   logic [m2tsphi_pkg::KIND_W-1:0]  kind_ff;
   logic [SW-1:0]                   stamp_ff;
   logic [SW-1:0]                   anchor_ff;
   logic [m2tsphi_pkg::HELD_W-1:0]  remain_ff;
   logic [DW-1:0]                   den_ff;
   logic [PW-1:0]                   quo_ff;
   logic [DW-1:0]                   rem_ff;
   logic [BCW-1:0]                  bit_cnt_ff;
   logic [SW-1:0]                   q_ff;
   logic [DW-1:0]                   r_ff;
   logic [DW-1:0]                   t_ff;
   logic [DW:0]                     d_ff;

   logic                            rsp_valid_ff;
   logic [m2tsphi_pkg::KIND_W-1:0]  rsp_kind_ff;
   logic [SW-1:0]                   rsp_stamp_ff;
   logic                            rsp_last_ff;

   logic                            out_free;
   logic [DW:0]                     rem_shift;
   logic                            div_ge;
   logic [DW:0]                     up_sum;
   logic                            up_wrap;
   logic [DW-1:0]                   r_up;
   logic [SW-1:0]                   q_up;
   logic [DW:0]                     dn_diff;
   logic                            dn_wrap;
   logic [DW-1:0]                   r_dn;
   logic [SW-1:0]                   q_dn;
   logic [DW:0]                     neg_d;
   logic [DW-1:0]                   abs_d;
   logic [DW:0]                     start_d;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(m2tsphi_pkg::RSP_DATA_W - SW){1'b0}}, rsp_stamp_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign pop        = (state_ff == B_IDLE) && !queue_status.empty;

   assign rem_shift = {rem_ff, quo_ff[PW-1]};
   assign div_ge    = (rem_shift >= {1'b0, den_ff});

   assign up_sum  = {1'b0, r_ff} + {1'b0, rem_ff};
   assign up_wrap = (up_sum >= {1'b0, den_ff});
   assign r_up    = up_wrap ? DW'(up_sum - {1'b0, den_ff}) : up_sum[DW-1:0];
   assign q_up    = q_ff + quo_ff[SW-1:0] + {{(SW-1){1'b0}}, up_wrap};

   assign dn_diff = {1'b0, r_ff} - {1'b0, rem_ff};
   assign dn_wrap = dn_diff[DW];
   assign r_dn    = dn_wrap ? DW'(dn_diff + {1'b0, den_ff}) : dn_diff[DW-1:0];
   assign q_dn    = q_ff - quo_ff[SW-1:0] - {{(SW-1){1'b0}}, dn_wrap};

   assign neg_d   = '0 - d_ff;
   assign abs_d   = d_ff[DW] ? neg_d[DW-1:0] : d_ff[DW-1:0];
   assign start_d = '0 - {head_cmd.offset[DW-1], head_cmd.offset};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!queue_status.empty) begin
               state_in = head_cmd.release_run ? B_DIV : B_TAIL;
            end
         end
         B_DIV: begin
            if (bit_cnt_ff == BCW'(1)) begin
               state_in = B_WALK;
            end
         end
         B_WALK: begin
            if (t_ff == abs_d) begin
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            if (out_free && (remain_ff == m2tsphi_pkg::HELD_W'(1))) begin
               state_in = has_tail_ff ? B_TAIL : B_IDLE;
            end
         end
         B_TAIL: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (((state_ff == B_EMIT) || (state_ff == B_TAIL)) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            if (!queue_status.empty) begin
               has_tail_ff <= head_cmd.has_tail;
               kind_ff     <= head_cmd.kind;
               stamp_ff    <= head_cmd.stamp;
               anchor_ff   <= head_cmd.anchor;
               remain_ff   <= head_cmd.count;
               den_ff      <= (head_cmd.rate_den == '0) ? DW'(1) : head_cmd.rate_den;
               quo_ff      <= head_cmd.rate_num;
               rem_ff      <= '0;
               bit_cnt_ff  <= BCW'(PW);
               q_ff        <= '0;
               r_ff        <= '0;
               t_ff        <= '0;
               d_ff        <= start_d;
            end
         end
         B_DIV: begin
            rem_ff     <= div_ge ? DW'(rem_shift - {1'b0, den_ff}) : rem_shift[DW-1:0];
            quo_ff     <= {quo_ff[PW-2:0], div_ge};
            bit_cnt_ff <= bit_cnt_ff - 1'b1;
         end
         B_WALK: begin
            if (t_ff != abs_d) begin
               t_ff <= t_ff + 1'b1;
               q_ff <= q_up;
               r_ff <= r_up;
            end
         end
         B_EMIT: begin
            if (out_free) begin
               rsp_kind_ff  <= m2tsphi_pkg::KIND_HELD;
               rsp_stamp_ff <= d_ff[DW] ? anchor_ff - q_ff : anchor_ff + q_ff;
               rsp_last_ff  <= (remain_ff == m2tsphi_pkg::HELD_W'(1)) && !has_tail_ff;
               remain_ff    <= remain_ff - 1'b1;
               d_ff         <= d_ff + 1'b1;
               if (d_ff[DW]) begin
                  t_ff <= t_ff - 1'b1;
                  q_ff <= q_dn;
                  r_ff <= r_dn;
               end else begin
                  t_ff <= t_ff + 1'b1;
                  q_ff <= q_up;
                  r_ff <= r_up;
               end
            end
         end
         B_TAIL: begin
            if (out_free) begin
               rsp_kind_ff  <= kind_ff;
               rsp_stamp_ff <= stamp_ff;
               rsp_last_ff  <= 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_EMIT) |-> (remain_ff != '0))
      else $error("Release loop entered with no packets left.");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (rem_ff < den_ff))
      else $error("Partial remainder not below the divisor.");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_WALK) |-> (t_ff <= abs_d))
      else $error("Accumulator walked past the first held packet.");
`endif

endmodule
`default_nettype wire

>>> sv/m2ts_pcr_header_interpolator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// M2TS PCR header interpolator
// Stamps 192-byte M2TS packets with 30-bit arrival headers interpolated
// between successive PCR values.
// ----------------------------------------------------------------------------
// Each request item is one packet or a drain request. The input side takes
// a new item only once the last one has been evaluated, and stalls while
// its command finds the command queue full. When enabled and the hold is
// not full, a packet without a PCR is only counted, so it produces no
// response item until a packet with a new PCR or a drain releases the held
// run. A release of the held packets in the release engine takes the
// command, runs a bit-serial division of the rate numerator by the packet
// distance, steps the interpolation accumulator to the first held packet,
// then emits one response item per cycle while the output is not stalled.
// A two-entry command queue sits between the classifier and the release
// engine, so new items keep arriving while a run is released, until it fills.
// ----------------------------------------------------------------------------
module m2ts_pcr_header_interpolator_unit #(
   parameter int unsigned HOLD_DEPTH = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,   // pcr_value [41:0], zero fill [47:42]
   input  wire  [1:0]  req_tuser,   // req_type [1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // header_stamp [29:0], zero fill [31:30]
   output logic [1:0]  rsp_tuser,   // release_kind [1:0]
   output logic        rsp_tlast,   // last_of_run
   input  wire         csr_wr_en,
   input  wire         csr_wr_data  // m2ts_enable
);

   logic                               push;
   logic                               pop;
   m2tsphi_pkg::cmd_type               push_cmd;
   m2tsphi_pkg::cmd_type               head_cmd;
   m2tsphi_pkg::queue_status_type      queue_status;

   m2tsphi_front #(
      .HOLD_DEPTH (HOLD_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .queue_status (queue_status),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   m2tsphi_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (queue_status)
   );

   m2tsphi_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_cmd     (head_cmd),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule
`default_nettype wire
